// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks clocked on i_clk and quiet while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a consequent holds in the same cycle as its antecedent.
`define YTS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define YTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: design/yts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yts_pkg
// Shared sizes, payload types and color arithmetic of the thumbnail scaler.
// ----------------------------------------------------------------------------
package yts_pkg;

    localparam int THUMB_W     = 160;
    localparam int THUMB_H     = 120;
    localparam int MAX_SRC_DIM = 2048;

    localparam int PIX_W       = 8;
    localparam int DIM_W       = 12;
    localparam int CFG_ADDR_W  = 1;
    localparam int SRC_POS_W   = $clog2(MAX_SRC_DIM);
    localparam int THUMB_COL_W = $clog2(THUMB_W);
    localparam int THUMB_ROW_W = $clog2(THUMB_H + 1);
    localparam int COL_CMP_W   = DIM_W + THUMB_COL_W;
    localparam int ROW_CMP_W   = DIM_W + THUMB_ROW_W;

    // Reset values of the frame size registers.
    localparam logic [DIM_W-1:0] SRC_W_RST = DIM_W'(320);
    localparam logic [DIM_W-1:0] SRC_H_RST = DIM_W'(240);

    // Chroma gains scaled by 2^RECIP_SHIFT/1000 and rounded up; exact for
    // offsets up to 128 in magnitude.
    localparam int RECIP_W     = 19;
    localparam int RECIP_SHIFT = 18;
    localparam int SCALE_W     = 9;
    localparam int PROD_W      = RECIP_W + PIX_W;
    localparam logic [RECIP_W-1:0] RECIP_R_V = RECIP_W'(367526);
    localparam logic [RECIP_W-1:0] RECIP_G_U = RECIP_W'(90178);
    localparam logic [RECIP_W-1:0] RECIP_G_V = RECIP_W'(187171);
    localparam logic [RECIP_W-1:0] RECIP_B_U = RECIP_W'(464520);
    localparam int SUM_W       = 11;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SRC_WIDTH  = 1'b0,
        CFG_SRC_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] chroma_blue;
        logic [PIX_W-1:0] chroma_red;
        logic             frame_start;
    } t_pix;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        t_rgb rgb;
        logic thumb_last;
    } t_res;

    typedef struct packed {
        logic emit;
        logic last;
    } t_sel;

    // Signed trunc((code - 128) * gain / 1000), gain given as its reciprocal.
    function automatic logic signed [SCALE_W-1:0] scale_chroma(
        input logic [PIX_W-1:0]   code,
        input logic [RECIP_W-1:0] recip
    );
        logic signed [SCALE_W-1:0] off;
        logic        [PIX_W-1:0]   mag;
        logic        [PROD_W-1:0]  prod;
        logic        [SCALE_W-1:0] quo;
        off  = $signed({1'b0, code}) - SCALE_W'(signed'(128));
        mag  = off[SCALE_W-1] ? PIX_W'(-off) : off[PIX_W-1:0];
        prod = PROD_W'(mag) * PROD_W'(recip);
        quo  = prod[RECIP_SHIFT +: SCALE_W];
        return off[SCALE_W-1] ? -$signed(quo) : $signed(quo);
    endfunction

    function automatic logic [PIX_W-1:0] clamp_u8(input logic signed [SUM_W-1:0] x);
        logic [PIX_W-1:0] y;
        if (x < 0) begin
            y = '0;
        end else if (x > SUM_W'(signed'(255))) begin
            y = '1;
        end else begin
            y = x[PIX_W-1:0];
        end
        return y;
    endfunction

endpackage
`default_nettype wire

// File: design/yts_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yts channel interfaces
// Valid/ready channels for source pixels, RGB words and register writes.
// ----------------------------------------------------------------------------
interface yts_pix_if;
    import yts_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] chroma_red;
    logic             frame_start;
    modport source (output valid, luma, chroma_blue, chroma_red, frame_start,
                    input ready);
    modport sink   (input valid, luma, chroma_blue, chroma_red, frame_start,
                    output ready);
endinterface

interface yts_rgb_if;
    import yts_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             thumb_last;
    modport source (output valid, red, green, blue, thumb_last, input ready);
    modport sink   (input valid, red, green, blue, thumb_last, output ready);
endinterface

interface yts_cfg_if;
    import yts_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [DIM_W-1:0]      data;
    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface
`default_nettype wire

// File: design/yts_color.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yts_color
// YUV to RGB conversion with truncating gains and 0..255 clamp.
// ----------------------------------------------------------------------------
module yts_color (
    input  wire logic [yts_pkg::PIX_W-1:0] i_luma,
    input  wire logic [yts_pkg::PIX_W-1:0] i_chroma_blue,
    input  wire logic [yts_pkg::PIX_W-1:0] i_chroma_red,
    output yts_pkg::t_rgb                  o_rgb
);
    import yts_pkg::*;

    logic signed [SCALE_W-1:0] r_v;
    logic signed [SCALE_W-1:0] g_u;
    logic signed [SCALE_W-1:0] g_v;
    logic signed [SCALE_W-1:0] b_u;
    logic signed [SUM_W-1:0]   y_s;
    logic signed [SUM_W-1:0]   sum_r;
    logic signed [SUM_W-1:0]   sum_g;
    logic signed [SUM_W-1:0]   sum_b;

    assign r_v = scale_chroma(i_chroma_red, RECIP_R_V);
    assign g_u = scale_chroma(i_chroma_blue, RECIP_G_U);
    assign g_v = scale_chroma(i_chroma_red, RECIP_G_V);
    assign b_u = scale_chroma(i_chroma_blue, RECIP_B_U);

    assign y_s   = $signed(SUM_W'(i_luma));
    assign sum_r = y_s + SUM_W'(r_v);
    assign sum_g = y_s - SUM_W'(g_u) - SUM_W'(g_v);
    assign sum_b = y_s + SUM_W'(b_u);

    assign o_rgb.red   = clamp_u8(sum_r);
    assign o_rgb.green = clamp_u8(sum_g);
    assign o_rgb.blue  = clamp_u8(sum_b);

endmodule
`default_nettype wire

// File: design/yts_select.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// yts_select
// Source and thumbnail position tracking and pixel selection.
// ----------------------------------------------------------------------------
module yts_select (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_adv,
    input  wire logic                      i_frame_start,
    input  wire logic [yts_pkg::DIM_W-1:0] i_src_w,
    input  wire logic [yts_pkg::DIM_W-1:0] i_src_h,
    output yts_pkg::t_sel                  o_sel
);
    import yts_pkg::*;

    logic [SRC_POS_W-1:0]   r_src_col,   n_src_col;
    logic [SRC_POS_W-1:0]   r_src_row,   n_src_row;
    logic [THUMB_COL_W-1:0] r_thumb_col, n_thumb_col;
    logic [THUMB_ROW_W-1:0] r_thumb_row, n_thumb_row;
    // Width and height seen when the pending target was chosen; the selected
    // source position is thumb_col*col_w/THUMB_W, thumb_row*row_h/THUMB_H.
    logic [DIM_W-1:0]       r_col_w,     n_col_w;
    logic [DIM_W-1:0]       r_row_h,     n_row_h;

    logic [SRC_POS_W-1:0]   c_src_col;
    logic [SRC_POS_W-1:0]   c_src_row;
    logic [THUMB_COL_W-1:0] c_thumb_col;
    logic [THUMB_ROW_W-1:0] c_thumb_row;
    logic [COL_CMP_W-1:0]   col_prod;
    logic [COL_CMP_W-1:0]   col_lo;
    logic [COL_CMP_W-1:0]   col_hi;
    logic [ROW_CMP_W-1:0]   row_prod;
    logic [ROW_CMP_W-1:0]   row_lo;
    logic [ROW_CMP_W-1:0]   row_hi;
    logic                   col_hit;
    logic                   row_hit;

    // Frame start zeroes every position before the pixel is judged.
    assign c_src_col   = i_frame_start ? '0 : r_src_col;
    assign c_src_row   = i_frame_start ? '0 : r_src_row;
    assign c_thumb_col = i_frame_start ? '0 : r_thumb_col;
    assign c_thumb_row = i_frame_start ? '0 : r_thumb_row;

    // floor(P/N) == s  <=>  s*N <= P <= s*N + N-1
    assign col_prod = COL_CMP_W'(c_thumb_col) * COL_CMP_W'(r_col_w);
    assign col_lo   = COL_CMP_W'(c_src_col) * COL_CMP_W'(THUMB_W);
    assign col_hi   = col_lo + COL_CMP_W'(THUMB_W - 1);
    assign col_hit  = (col_prod >= col_lo) && (col_prod <= col_hi);

    assign row_prod = ROW_CMP_W'(c_thumb_row) * ROW_CMP_W'(r_row_h);
    assign row_lo   = ROW_CMP_W'(c_src_row) * ROW_CMP_W'(THUMB_H);
    assign row_hi   = row_lo + ROW_CMP_W'(THUMB_H - 1);
    assign row_hit  = (row_prod >= row_lo) && (row_prod <= row_hi);

    assign o_sel.emit = (c_thumb_row < THUMB_ROW_W'(THUMB_H)) && col_hit && row_hit;
    assign o_sel.last = (c_thumb_col == THUMB_COL_W'(THUMB_W - 1))
                     && (c_thumb_row == THUMB_ROW_W'(THUMB_H - 1));

    always_comb begin
        n_src_col   = r_src_col;
        n_src_row   = r_src_row;
        n_thumb_col = r_thumb_col;
        n_thumb_row = r_thumb_row;
        n_col_w     = r_col_w;
        n_row_h     = r_row_h;
        if (i_adv) begin
            n_thumb_col = c_thumb_col;
            n_thumb_row = c_thumb_row;
            if (o_sel.emit) begin
                if (c_thumb_col == THUMB_COL_W'(THUMB_W - 1)) begin
                    n_thumb_col = '0;
                    n_thumb_row = c_thumb_row + 1'b1;
                    n_row_h     = i_src_h;
                end else begin
                    n_thumb_col = c_thumb_col + 1'b1;
                    n_col_w     = i_src_w;
                end
            end
            // Wrap at the line end; hold the row at its top value.
            if (DIM_W'(c_src_col) >= i_src_w - 1'b1) begin
                n_src_col = '0;
                n_src_row = (c_src_row < SRC_POS_W'(MAX_SRC_DIM - 1))
                          ? c_src_row + 1'b1 : c_src_row;
            end else begin
                n_src_col = c_src_col + 1'b1;
                n_src_row = c_src_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col   <= '0;
            r_src_row   <= '0;
            r_thumb_col <= '0;
            r_thumb_row <= '0;
            r_col_w     <= '0;
            r_row_h     <= '0;
        end else begin
            r_src_col   <= n_src_col;
            r_src_row   <= n_src_row;
            r_thumb_col <= n_thumb_col;
            r_thumb_row <= n_thumb_row;
            r_col_w     <= n_col_w;
            r_row_h     <= n_row_h;
        end
    end

    `YTS_ASSERT_SAME(a_frame_start_emits, i_adv && i_frame_start, o_sel.emit, "frame start pixel not selected")
    `YTS_ASSERT_NEXT(a_last_ends_thumb, i_adv && o_sel.emit && o_sel.last, r_thumb_row == THUMB_ROW_W'(THUMB_H), "thumbnail did not close after last pixel")
    `YTS_ASSERT_NEXT(a_row_monotonic, i_adv && !i_frame_start, r_src_row >= $past(r_src_row), "source row went back without frame start")

endmodule
`default_nettype wire

// File: design/yuv_thumbnail_scaler_rgb.sv
// Throughput: one source pixel per clock while the output is not stalled, set by
// the single pass from the input register through selection and color math into
// the output register.
// Reset: synchronous, active low; clears positions, valid flags and restores
// the frame size registers to 320 x 240.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yuv_thumbnail_scaler_rgb
// Nearest-neighbor downscale of a YUV pixel stream to a fixed-size RGB
// thumbnail.
// ----------------------------------------------------------------------------
module yuv_thumbnail_scaler_rgb (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    yts_pix_if.sink   i_pix,
    yts_rgb_if.source o_rgb,
    yts_cfg_if.sink   i_cfg
);
    import yts_pkg::*;

    // Frame size registers, raw as written.
    logic [DIM_W-1:0] r_src_width,  n_src_width;
    logic [DIM_W-1:0] r_src_height, n_src_height;
    // Effective size: clamp to THUMB..MAX so only downscaling happens.
    logic [DIM_W-1:0] eff_w;
    logic [DIM_W-1:0] eff_h;

    // Input register: holds one source pixel until it is judged.
    logic r_in_valid, n_in_valid;
    t_pix r_in,       n_in;
    // Output register: holds one RGB word until the sink takes it.
    logic r_out_valid, n_out_valid;
    t_res r_out,       n_out;

    logic in_take;
    logic adv;
    t_sel sel;
    t_rgb rgb;

    // ---------------------------------------------------------------- config
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_src_width  = r_src_width;
        n_src_height = r_src_height;
        if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.addr))
                CFG_SRC_WIDTH:  n_src_width  = i_cfg.data;
                CFG_SRC_HEIGHT: n_src_height = i_cfg.data;
            endcase
        end
    end

    always_comb begin
        if (r_src_width < DIM_W'(THUMB_W)) begin
            eff_w = DIM_W'(THUMB_W);
        end else if (r_src_width > DIM_W'(MAX_SRC_DIM)) begin
            eff_w = DIM_W'(MAX_SRC_DIM);
        end else begin
            eff_w = r_src_width;
        end
        if (r_src_height < DIM_W'(THUMB_H)) begin
            eff_h = DIM_W'(THUMB_H);
        end else if (r_src_height > DIM_W'(MAX_SRC_DIM)) begin
            eff_h = DIM_W'(MAX_SRC_DIM);
        end else begin
            eff_h = r_src_height;
        end
    end

    // -------------------------------------------------------------- datapath
    // Advance the held pixel whenever the output register is free or drains
    // this cycle; a pixel that is not selected just retires.
    assign adv         = r_in_valid && (!r_out_valid || o_rgb.ready);
    assign i_pix.ready = !r_in_valid || adv;
    assign in_take     = i_pix.valid && i_pix.ready;

    yts_select u_select (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_frame_start (r_in.frame_start),
        .i_src_w       (eff_w),
        .i_src_h       (eff_h),
        .o_sel         (sel)
    );

    yts_color u_color (
        .i_luma        (r_in.luma),
        .i_chroma_blue (r_in.chroma_blue),
        .i_chroma_red  (r_in.chroma_red),
        .o_rgb         (rgb)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        n_in       = r_in;
        if (in_take) begin
            n_in_valid = 1'b1;
            n_in       = '{luma:        i_pix.luma,
                           chroma_blue: i_pix.chroma_blue,
                           chroma_red:  i_pix.chroma_red,
                           frame_start: i_pix.frame_start};
        end else if (adv) begin
            n_in_valid = 1'b0;
        end

        // Load a word on a selected pixel; otherwise drop the word once taken.
        n_out = r_out;
        if (adv) begin
            n_out_valid = sel.emit;
            if (sel.emit) begin
                n_out = '{rgb: rgb, thumb_last: sel.last};
            end
        end else begin
            n_out_valid = r_out_valid && !o_rgb.ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= SRC_W_RST;
            r_src_height <= SRC_H_RST;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_src_width  <= n_src_width;
            r_src_height <= n_src_height;
            r_in_valid   <= n_in_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_out <= n_out;
    end

    assign o_rgb.valid      = r_out_valid;
    assign o_rgb.red        = r_out.rgb.red;
    assign o_rgb.green      = r_out.rgb.green;
    assign o_rgb.blue       = r_out.rgb.blue;
    assign o_rgb.thumb_last = r_out.thumb_last;

endmodule
`default_nettype wire
